FILE: sv/etrc_pkg.sv
// Shared types and constants of the event/track rate counter.
// Used by etrc_front, etrc_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package etrc_pkg;

  localparam int unsigned CNT_W = 40;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam int unsigned PID_BIT = 2;
  localparam int unsigned FEMTO_BIT = 3;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_TRACK = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COUNT,
    ST_TRACK
  } back_state_e;

  // One classified item as it waits in the queue between front and back.
  typedef struct packed {
    logic        is_track;
    logic [31:0] run_id;
    logic        cent_ok;
    logic [7:0]  cent;
    logic [7:0]  species;
    logic        pid;
    logic        femto;
  } cmd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

FILE: sv/etrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
`timescale 1ns / 1ps
`default_nettype none
module etrc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: sv/etrc_front.sv
// Front part: accepts items, classifies them and holds them in a two-entry queue.
// Depends on etrc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module etrc_front #(
  parameter int unsigned CENT_BIN_COUNT = 16,
  parameter int unsigned SPECIES_COUNT  = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          opcode_i,
  input  wire logic [31:0]   run_id_i,
  input  wire logic [7:0]    centrality_i,
  input  wire logic [7:0]    species_code_i,
  input  wire logic [31:0]   sel_flags_i,
  output logic               q_valid_o,
  output etrc_pkg::cmd_t     q_data_o,
  input  wire logic          q_pop_i
);
  import etrc_pkg::*;

  cmd_t       cls;
  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  // A negative centrality has its sign bit set and never counts.
  always_comb begin
    cls.is_track = (opcode_i == OP_TRACK);
    cls.run_id   = run_id_i;
    cls.cent_ok  = !centrality_i[7] && ({1'b0, centrality_i} < 9'(CENT_BIN_COUNT));
    cls.cent     = centrality_i;
    cls.species  = ({1'b0, species_code_i} < 9'(SPECIES_COUNT)) ? species_code_i : 8'd0;
    cls.pid      = sel_flags_i[PID_BIT];
    cls.femto    = sel_flags_i[FEMTO_BIT];
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

FILE: sv/etrc_back.sv
// Back part: runs the run-table scan and all counter updates, and holds the result.
// Depends on etrc_pkg and etrc_ram.
`timescale 1ns / 1ps
`default_nettype none
module etrc_back #(
  parameter int unsigned MAX_RUNS       = 64,
  parameter int unsigned CENT_BIN_COUNT = 16,
  parameter int unsigned SPECIES_COUNT  = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire etrc_pkg::cmd_t   q_data_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [5:0]            run_slot_o,
  output logic                  run_dropped_o,
  output logic [39:0]           run_count_o,
  output logic [39:0]           cent_count_o,
  output logic [2:0]            species_o,
  output logic [39:0]           species_total_o,
  output logic [39:0]           pid_count_o,
  output logic [39:0]           femto_count_o,
  output logic [39:0]           both_count_o
);
  import etrc_pkg::*;

  localparam int unsigned RUN_AW  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int unsigned RUN_CW  = $clog2(MAX_RUNS + 1);
  localparam int unsigned CENT_AW = (CENT_BIN_COUNT > 1) ? $clog2(CENT_BIN_COUNT) : 1;
  localparam int unsigned SP_W    = $clog2(SPECIES_COUNT);

  back_state_e       state_q, state_d;
  cmd_t              cur_q;
  logic [RUN_CW-1:0] scan_q, scan_d;
  logic [RUN_CW-1:0] scan_nxt;
  logic [RUN_AW-1:0] slot_q, slot_d;
  logic              new_q, new_d;
  logic              drop_q, drop_d;
  logic [RUN_CW-1:0] runs_used_q;
  logic [CENT_BIN_COUNT-1:0] cent_vld_q;

  logic              id_re;
  logic [RUN_AW-1:0] id_raddr;
  logic [31:0]       id_rdata;
  logic              cnt_re;
  logic [CNT_W-1:0]  cnt_rdata;
  logic              cent_re;
  logic [CNT_W-1:0]  cent_rdata;
  logic              commit_ev;
  logic              commit_tr;
  logic              out_free;

  logic [CENT_AW-1:0] cent_idx;
  logic [CNT_W-1:0]   cent_new;
  logic [CNT_W-1:0]   run_cnt_new;

  logic [SP_W-1:0]  sp;
  logic [CNT_W-1:0] tot_q   [SPECIES_COUNT];
  logic [CNT_W-1:0] pid_q   [SPECIES_COUNT];
  logic [CNT_W-1:0] femto_q [SPECIES_COUNT];
  logic [CNT_W-1:0] both_q  [SPECIES_COUNT];
  logic [CNT_W-1:0] tot_new, pid_new, femto_new, both_new;
  logic             both_hit;

  logic             out_valid_q;
  logic [5:0]       run_slot_q;
  logic             run_dropped_q;
  logic [CNT_W-1:0] run_count_q, cent_count_q;
  logic [2:0]       species_q;
  logic [CNT_W-1:0] species_total_q, pid_count_q, femto_count_q, both_count_q;

  etrc_ram #(.WIDTH(32), .DEPTH(MAX_RUNS)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (commit_ev && new_q),
    .waddr_i (slot_q),
    .wdata_i (cur_q.run_id),
    .re_i    (id_re),
    .raddr_i (id_raddr),
    .rdata_o (id_rdata)
  );

  // A freshly allocated slot starts from zero, so its old content is never used.
  etrc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_RUNS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (commit_ev && !drop_q),
    .waddr_i (slot_q),
    .wdata_i (run_cnt_new),
    .re_i    (cnt_re),
    .raddr_i (slot_d),
    .rdata_o (cnt_rdata)
  );

  etrc_ram #(.WIDTH(CNT_W), .DEPTH(CENT_BIN_COUNT)) u_cent_ram (
    .clk_i   (clk_i),
    .we_i    (commit_ev && cur_q.cent_ok),
    .waddr_i (cent_idx),
    .wdata_i (cent_new),
    .re_i    (cent_re),
    .raddr_i (q_data_i.cent[CENT_AW-1:0]),
    .rdata_o (cent_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign scan_nxt = scan_q + RUN_CW'(1);

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    slot_d    = slot_q;
    new_d     = new_q;
    drop_d    = drop_q;
    q_pop_o   = 1'b0;
    id_re     = 1'b0;
    id_raddr  = scan_q[RUN_AW-1:0];
    cnt_re    = 1'b0;
    cent_re   = 1'b0;
    commit_ev = 1'b0;
    commit_tr = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_data_i.is_track) begin
            state_d = ST_TRACK;
          end else begin
            cent_re  = 1'b1;
            id_re    = 1'b1;
            id_raddr = '0;
            scan_d   = '0;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // The id read issued last cycle belongs to the entry at scan_q.
        if (scan_q < runs_used_q) begin
          if (id_rdata == cur_q.run_id) begin
            slot_d  = scan_q[RUN_AW-1:0];
            new_d   = 1'b0;
            drop_d  = 1'b0;
            cnt_re  = 1'b1;
            state_d = ST_COUNT;
          end else begin
            scan_d   = scan_nxt;
            id_re    = 1'b1;
            id_raddr = scan_nxt[RUN_AW-1:0];
          end
        end else begin
          if (runs_used_q < RUN_CW'(MAX_RUNS)) begin
            slot_d = runs_used_q[RUN_AW-1:0];
            new_d  = 1'b1;
            drop_d = 1'b0;
          end else begin
            slot_d = '0;
            new_d  = 1'b0;
            drop_d = 1'b1;
          end
          cnt_re  = 1'b1;
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (out_free) begin
          commit_ev = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_TRACK: begin
        if (out_free) begin
          commit_tr = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    slot_q <= slot_d;
    new_q  <= new_d;
    drop_q <= drop_d;
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  // Event arithmetic. A bin that was never written reads as zero.
  assign cent_idx    = cur_q.cent[CENT_AW-1:0];
  assign cent_new    = sat_inc(cent_vld_q[cent_idx] ? cent_rdata : '0);
  assign run_cnt_new = new_q ? CNT_W'(1) : sat_inc(cnt_rdata);

  // Track arithmetic on the flip-flop counters.
  assign sp        = cur_q.species[SP_W-1:0];
  assign both_hit  = cur_q.pid && cur_q.femto;
  assign tot_new   = sat_inc(tot_q[sp]);
  assign pid_new   = cur_q.pid ? sat_inc(pid_q[sp]) : pid_q[sp];
  assign femto_new = cur_q.femto ? sat_inc(femto_q[sp]) : femto_q[sp];
  assign both_new  = both_hit ? sat_inc(both_q[sp]) : both_q[sp];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      runs_used_q <= '0;
      cent_vld_q  <= '0;
      for (int i = 0; i < SPECIES_COUNT; i++) begin
        tot_q[i]   <= '0;
        pid_q[i]   <= '0;
        femto_q[i] <= '0;
        both_q[i]  <= '0;
      end
    end else begin
      if (commit_ev && new_q) begin
        runs_used_q <= runs_used_q + RUN_CW'(1);
      end
      if (commit_ev && cur_q.cent_ok) begin
        cent_vld_q[cent_idx] <= 1'b1;
      end
      if (commit_tr) begin
        tot_q[sp]   <= tot_new;
        pid_q[sp]   <= pid_new;
        femto_q[sp] <= femto_new;
        both_q[sp]  <= both_new;
      end
    end
  end

  // Result register: takes a new result whenever the previous one is gone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_ev || commit_tr) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_ev) begin
      run_slot_q      <= drop_q ? 6'd0 : 6'(slot_q);
      run_dropped_q   <= drop_q;
      run_count_q     <= drop_q ? '0 : run_cnt_new;
      cent_count_q    <= cur_q.cent_ok ? cent_new : '0;
      species_q       <= 3'd0;
      species_total_q <= '0;
      pid_count_q     <= '0;
      femto_count_q   <= '0;
      both_count_q    <= '0;
    end else if (commit_tr) begin
      run_slot_q      <= 6'd0;
      run_dropped_q   <= 1'b0;
      run_count_q     <= '0;
      cent_count_q    <= '0;
      species_q       <= 3'(sp);
      species_total_q <= tot_new;
      pid_count_q     <= pid_new;
      femto_count_q   <= femto_new;
      both_count_q    <= both_new;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign run_slot_o      = run_slot_q;
  assign run_dropped_o   = run_dropped_q;
  assign run_count_o     = run_count_q;
  assign cent_count_o    = cent_count_q;
  assign species_o       = species_q;
  assign species_total_o = species_total_q;
  assign pid_count_o     = pid_count_q;
  assign femto_count_o   = femto_count_q;
  assign both_count_o    = both_count_q;

endmodule
`default_nettype wire

FILE: sv/event_track_rate_counter_unit.sv
// Event/track rate counter: input channel, one result per item on the output channel.
// Items enter via in_valid_i/in_stall_o; the front classifies them into a two-entry
// queue, the back scans the run table and updates all saturating 40-bit counters.
// A result is presented on out_valid_o and held until a cycle with out_stall_i low.
// An event item goes through the back part's run scan, which compares run-table
// entries one by one until a match (up to the number of runs stored), as the id
// memory yields one entry a cycle, and then through the counter update.
// A new item is accepted while the queue has room, also while the back is busy or a
// result waits. The back part takes the next item from the queue only when it is
// through with the last one, after its run scan and counter update.
// Reset clears all counters, the run table fill count and the queue at once;
// no clearing pass follows. A stalled result stops the back part, the queue then
// fills and in_stall_o rises.
// Depends on etrc_pkg, etrc_front, etrc_back and etrc_ram.
`timescale 1ns / 1ps
`default_nettype none
module event_track_rate_counter_unit #(
  parameter int unsigned MAX_RUNS       = 64,
  parameter int unsigned CENT_BIN_COUNT = 16,
  parameter int unsigned SPECIES_COUNT  = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        opcode_i,
  input  wire logic [31:0] run_id_i,
  input  wire logic [7:0]  centrality_i,
  input  wire logic [7:0]  species_code_i,
  input  wire logic [31:0] sel_flags_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [5:0]       run_slot_o,
  output logic             run_dropped_o,
  output logic [39:0]      run_count_o,
  output logic [39:0]      cent_count_o,
  output logic [2:0]       species_o,
  output logic [39:0]      species_total_o,
  output logic [39:0]      pid_count_o,
  output logic [39:0]      femto_count_o,
  output logic [39:0]      both_count_o
);
  import etrc_pkg::*;

  logic q_valid;
  cmd_t q_data;
  logic q_pop;

  etrc_front #(
    .CENT_BIN_COUNT (CENT_BIN_COUNT),
    .SPECIES_COUNT  (SPECIES_COUNT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .run_id_i       (run_id_i),
    .centrality_i   (centrality_i),
    .species_code_i (species_code_i),
    .sel_flags_i    (sel_flags_i),
    .q_valid_o      (q_valid),
    .q_data_o       (q_data),
    .q_pop_i        (q_pop)
  );

  etrc_back #(
    .MAX_RUNS       (MAX_RUNS),
    .CENT_BIN_COUNT (CENT_BIN_COUNT),
    .SPECIES_COUNT  (SPECIES_COUNT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .run_slot_o      (run_slot_o),
    .run_dropped_o   (run_dropped_o),
    .run_count_o     (run_count_o),
    .cent_count_o    (cent_count_o),
    .species_o       (species_o),
    .species_total_o (species_total_o),
    .pid_count_o     (pid_count_o),
    .femto_count_o   (femto_count_o),
    .both_count_o    (both_count_o)
  );

endmodule
`default_nettype wire
